### rtl/trs_matrix_compose_top_defines.svh
// Assertion macros for the TRS matrix compose block.
`ifndef TRS_MATRIX_COMPOSE_TOP_DEFINES_SVH
`define TRS_MATRIX_COMPOSE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TRS_MC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trs_matrix_compose: implication check failed");

// Implication after a fixed number of cycles.
`define TRS_MC_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("trs_matrix_compose: delayed check failed");

`endif

### rtl/trs_mc_pkg.sv
// Shared types and constants of the TRS matrix compose block.
package trs_mc_pkg;

  localparam int unsigned PIPE_LATENCY = 6;

  typedef logic signed [15:0] fix16_t;
  typedef logic signed [21:0] rot_ent_t;
  typedef rot_ent_t rot_mat_t [3][3];
  typedef logic signed [26:0] rv_ent_t;
  typedef rv_ent_t rv_mat_t [3][3];
  typedef logic signed [31:0] fix32_t;
  typedef fix32_t scl_vec_t [3];
  typedef fix32_t out_mat_t [3][3];

  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_PARENT_POS   = 2'd0;
  localparam cfg_addr_t CFG_PARENT_ROT   = 2'd1;
  localparam cfg_addr_t CFG_PARENT_SCALE = 2'd2;

  localparam logic [47:0] PARENT_POS_RST   = 48'h0000_0000_0000;
  localparam logic [63:0] PARENT_ROT_RST   = 64'h0000_0000_0000_4000;
  localparam logic [47:0] PARENT_SCALE_RST = 48'h0100_0100_0100;

endpackage

### rtl/trs_matrix_compose_top.sv
// Top level: TRS model matrix from a local pose under a configured parent pose.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// The six stages are set by the quaternion products, the 3x3 product and the scaling.
// Reset (synchronous, rst_n low) clears all pipeline valids and loads the identity parent.
module trs_matrix_compose_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  trs_mc_pkg::fix16_t  in_pos_x,
  input  trs_mc_pkg::fix16_t  in_pos_y,
  input  trs_mc_pkg::fix16_t  in_pos_z,
  input  trs_mc_pkg::fix16_t  in_rot_w,
  input  trs_mc_pkg::fix16_t  in_rot_x,
  input  trs_mc_pkg::fix16_t  in_rot_y,
  input  trs_mc_pkg::fix16_t  in_rot_z,
  input  trs_mc_pkg::fix16_t  in_scale_x,
  input  trs_mc_pkg::fix16_t  in_scale_y,
  input  trs_mc_pkg::fix16_t  in_scale_z,
  input  logic                cfg_we,
  input  trs_mc_pkg::cfg_addr_t cfg_addr,
  input  logic [63:0]         cfg_wdata,
  output logic                out_strobe,
  output trs_mc_pkg::fix32_t  out_m00,
  output trs_mc_pkg::fix32_t  out_m01,
  output trs_mc_pkg::fix32_t  out_m02,
  output trs_mc_pkg::fix32_t  out_m03,
  output trs_mc_pkg::fix32_t  out_m10,
  output trs_mc_pkg::fix32_t  out_m11,
  output trs_mc_pkg::fix32_t  out_m12,
  output trs_mc_pkg::fix32_t  out_m13,
  output trs_mc_pkg::fix32_t  out_m20,
  output trs_mc_pkg::fix32_t  out_m21,
  output trs_mc_pkg::fix32_t  out_m22,
  output trs_mc_pkg::fix32_t  out_m23
);

`include "trs_matrix_compose_top_defines.svh"

  logic [47:0] par_pos_r;
  logic [63:0] par_rot_r;
  logic [47:0] par_scale_r;

  logic in_xfer;

  trs_mc_pkg::scl_vec_t s_r [4];
  trs_mc_pkg::scl_vec_t t_r [6];
  trs_mc_pkg::scl_vec_t s_nxt;
  trs_mc_pkg::scl_vec_t t_nxt;

  logic                 lm_valid;
  logic                 pm_valid;
  trs_mc_pkg::rot_mat_t lm;
  trs_mc_pkg::rot_mat_t pm;
  logic                 rv_valid;
  trs_mc_pkg::rv_mat_t  rv;
  trs_mc_pkg::out_mat_t m_out;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_pos_r   <= trs_mc_pkg::PARENT_POS_RST;
      par_rot_r   <= trs_mc_pkg::PARENT_ROT_RST;
      par_scale_r <= trs_mc_pkg::PARENT_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        trs_mc_pkg::CFG_PARENT_POS:   par_pos_r   <= cfg_wdata[47:0];
        trs_mc_pkg::CFG_PARENT_ROT:   par_rot_r   <= cfg_wdata;
        trs_mc_pkg::CFG_PARENT_SCALE: par_scale_r <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [16:0] sum;
    logic signed [15:0] pl;
    logic signed [15:0] sl;
    logic signed [15:0] lp [3];
    logic signed [15:0] ls [3];
    lp[0] = in_pos_x;
    lp[1] = in_pos_y;
    lp[2] = in_pos_z;
    ls[0] = in_scale_x;
    ls[1] = in_scale_y;
    ls[2] = in_scale_z;
    for (int c = 0; c < 3; c++) begin
      pl       = par_pos_r[16*c +: 16];
      sl       = par_scale_r[16*c +: 16];
      sum      = {pl[15], pl} + {lp[c][15], lp[c]};
      t_nxt[c] = {{7{sum[16]}}, sum, 8'h00};
      s_nxt[c] = sl * ls[c];
    end
  end

  always_ff @(posedge clk) begin
    s_r[0] <= s_nxt;
    t_r[0] <= t_nxt;
    for (int i = 1; i < 4; i++) begin
      s_r[i] <= s_r[i-1];
    end
    for (int i = 1; i < 6; i++) begin
      t_r[i] <= t_r[i-1];
    end
  end

  trs_mc_qmat u_qmat_local (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_xfer),
    .q_w       (in_rot_w),
    .q_x       (in_rot_x),
    .q_y       (in_rot_y),
    .q_z       (in_rot_z),
    .out_valid (lm_valid),
    .m         (lm)
  );

  trs_mc_qmat u_qmat_parent (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_xfer),
    .q_w       (par_rot_r[15:0]),
    .q_x       (par_rot_r[31:16]),
    .q_y       (par_rot_r[47:32]),
    .q_z       (par_rot_r[63:48]),
    .out_valid (pm_valid),
    .m         (pm)
  );

  trs_mc_matmul u_matmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lm_valid && pm_valid),
    .pm        (pm),
    .lm        (lm),
    .out_valid (rv_valid),
    .rv        (rv)
  );

  trs_mc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rv_valid),
    .rv        (rv),
    .s         (s_r[3]),
    .out_valid (out_strobe),
    .m         (m_out)
  );

  assign out_m00 = m_out[0][0];
  assign out_m01 = m_out[0][1];
  assign out_m02 = m_out[0][2];
  assign out_m03 = t_r[5][0];
  assign out_m10 = m_out[1][0];
  assign out_m11 = m_out[1][1];
  assign out_m12 = m_out[1][2];
  assign out_m13 = t_r[5][1];
  assign out_m20 = m_out[2][0];
  assign out_m21 = m_out[2][1];
  assign out_m22 = m_out[2][2];
  assign out_m23 = t_r[5][2];

  `TRS_MC_ASSERT_DELAY(a_xfer_gives_result, in_xfer, trs_mc_pkg::PIPE_LATENCY, out_strobe)
  `TRS_MC_ASSERT_IMPLY(a_result_had_xfer, out_strobe, $past(in_xfer, trs_mc_pkg::PIPE_LATENCY))
  `TRS_MC_ASSERT_IMPLY(a_stages_aligned, rv_valid, $past(lm_valid && pm_valid, 2))

endmodule

### rtl/trs_mc_qmat.sv
// Two-stage quaternion to rotation matrix unit, Q2.14 in, Q.16 out.
module trs_mc_qmat (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  trs_mc_pkg::fix16_t   q_w,
  input  trs_mc_pkg::fix16_t   q_x,
  input  trs_mc_pkg::fix16_t   q_y,
  input  trs_mc_pkg::fix16_t   q_z,
  output logic                 out_valid,
  output trs_mc_pkg::rot_mat_t m
);

  localparam logic signed [33:0] Q_ONE = 34'sd268435456;

  logic v1_r;
  logic v2_r;
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  trs_mc_pkg::rot_mat_t m_r;
  trs_mc_pkg::rot_mat_t m_nxt;

  function automatic logic signed [33:0] ext34(input logic signed [31:0] a);
    return {{2{a[31]}}, a};
  endfunction

  function automatic trs_mc_pkg::rot_ent_t rnd12(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v + 34'sd2048;
    return t[33:12];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    xx_r <= q_x * q_x;
    yy_r <= q_y * q_y;
    zz_r <= q_z * q_z;
    xy_r <= q_x * q_y;
    xz_r <= q_x * q_z;
    yz_r <= q_y * q_z;
    wx_r <= q_w * q_x;
    wy_r <= q_w * q_y;
    wz_r <= q_w * q_z;
  end

  always_comb begin
    m_nxt[0][0] = rnd12(Q_ONE - ((ext34(yy_r) + ext34(zz_r)) <<< 1));
    m_nxt[0][1] = rnd12((ext34(xy_r) - ext34(wz_r)) <<< 1);
    m_nxt[0][2] = rnd12((ext34(xz_r) + ext34(wy_r)) <<< 1);
    m_nxt[1][0] = rnd12((ext34(xy_r) + ext34(wz_r)) <<< 1);
    m_nxt[1][1] = rnd12(Q_ONE - ((ext34(xx_r) + ext34(zz_r)) <<< 1));
    m_nxt[1][2] = rnd12((ext34(yz_r) - ext34(wx_r)) <<< 1);
    m_nxt[2][0] = rnd12((ext34(xz_r) - ext34(wy_r)) <<< 1);
    m_nxt[2][1] = rnd12((ext34(yz_r) + ext34(wx_r)) <<< 1);
    m_nxt[2][2] = rnd12(Q_ONE - ((ext34(xx_r) + ext34(yy_r)) <<< 1));
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end

  assign out_valid = v2_r;
  assign m         = m_r;

endmodule

### rtl/trs_mc_matmul.sv
// Two-stage 3x3 rotation product, Q.16 entries, rounded back to Q.16.
module trs_mc_matmul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  trs_mc_pkg::rot_mat_t pm,
  input  trs_mc_pkg::rot_mat_t lm,
  output logic                 out_valid,
  output trs_mc_pkg::rv_mat_t  rv
);

  logic v1_r;
  logic v2_r;
  logic signed [43:0] prod_r [3][3][3];
  trs_mc_pkg::rv_mat_t rv_r;
  trs_mc_pkg::rv_mat_t rv_nxt;

  function automatic logic signed [45:0] ext46(input logic signed [43:0] a);
    return {{2{a[43]}}, a};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r][c][k] <= pm[r][k] * lm[k][c];
        end
      end
    end
  end

  always_comb begin
    logic signed [45:0] acc;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = ext46(prod_r[r][c][0]) + ext46(prod_r[r][c][1]) +
              ext46(prod_r[r][c][2]) + 46'sd32768;
        rv_nxt[r][c] = acc[42:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    rv_r <= rv_nxt;
  end

  assign out_valid = v2_r;
  assign rv        = rv_r;

endmodule

### rtl/trs_mc_scale.sv
// Two-stage column scaling with Q.16 rounding and 32-bit saturation.
module trs_mc_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  trs_mc_pkg::rv_mat_t  rv,
  input  trs_mc_pkg::scl_vec_t s,
  output logic                 out_valid,
  output trs_mc_pkg::out_mat_t m
);

  logic v1_r;
  logic v2_r;
  logic signed [58:0] prod_r [3][3];
  trs_mc_pkg::out_mat_t m_r;
  trs_mc_pkg::out_mat_t m_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= rv[r][c] * s[c];
      end
    end
  end

  always_comb begin
    logic signed [59:0] t;
    logic signed [43:0] q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        t = {prod_r[r][c][58], prod_r[r][c]} + 60'sd32768;
        q = t[59:16];
        if ((&q[43:31]) || !(|q[43:31])) begin
          m_nxt[r][c] = q[31:0];
        end else if (q[43]) begin
          m_nxt[r][c] = 32'sh8000_0000;
        end else begin
          m_nxt[r][c] = 32'sh7FFF_FFFF;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end

  assign out_valid = v2_r;
  assign m         = m_r;

endmodule

### tb/tb_trs_matrix_compose_top.sv
// Testbench for trs_matrix_compose_top: directed and random poses under changing parents, scoreboard check.
`timescale 1ns / 1ps

module tb_trs_matrix_compose_top;

  localparam trs_mc_pkg::cfg_addr_t CFG_ADDR_SPARE = 2'd3;
  localparam int        QUIET_LIMIT    = 1000;
  localparam int        PHASES         = 11;
  localparam int        PHASE_ITEMS    = 150;

  typedef struct {
    trs_mc_pkg::fix16_t pos [3];
    trs_mc_pkg::fix16_t rot [4];
    trs_mc_pkg::fix16_t scl [3];
  } pose_t;

  typedef struct {
    trs_mc_pkg::fix32_t m [12];
  } matrix_t;

  typedef longint mat3_t [3][3];

  class matrix_scoreboard;
    logic [47:0] par_pos;
    logic [63:0] par_rot;
    logic [47:0] par_scale;
    matrix_t     expected_matrices [$];
    int          errors;

    function new();
      par_pos   = trs_mc_pkg::PARENT_POS_RST;
      par_rot   = trs_mc_pkg::PARENT_ROT_RST;
      par_scale = trs_mc_pkg::PARENT_SCALE_RST;
      errors    = 0;
    endfunction

    function void write_reg(trs_mc_pkg::cfg_addr_t addr, logic [63:0] data);
      case (addr)
        trs_mc_pkg::CFG_PARENT_POS:   par_pos   = data[47:0];
        trs_mc_pkg::CFG_PARENT_ROT:   par_rot   = data;
        trs_mc_pkg::CFG_PARENT_SCALE: par_scale = data[47:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_matrices.size();
    endfunction

    function longint lane(logic [63:0] v, int k);
      return longint'(trs_mc_pkg::fix16_t'(v[16*k +: 16]));
    endfunction

    // round half up, then drop n fraction bits
    function longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function trs_mc_pkg::fix32_t clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return trs_mc_pkg::fix32_t'(v);
    endfunction

    function void quat_to_mat(longint w, longint x, longint y, longint z, output mat3_t m);
      longint one;
      one = longint'(1) <<< 28;
      m[0][0] = round_shift(one - 2 * (y * y + z * z), 12);
      m[0][1] = round_shift(2 * (x * y - w * z), 12);
      m[0][2] = round_shift(2 * (x * z + w * y), 12);
      m[1][0] = round_shift(2 * (x * y + w * z), 12);
      m[1][1] = round_shift(one - 2 * (x * x + z * z), 12);
      m[1][2] = round_shift(2 * (y * z - w * x), 12);
      m[2][0] = round_shift(2 * (x * z - w * y), 12);
      m[2][1] = round_shift(2 * (y * z + w * x), 12);
      m[2][2] = round_shift(one - 2 * (x * x + y * y), 12);
    endfunction

    function matrix_t compose_matrix(pose_t p);
      mat3_t   pm;
      mat3_t   lm;
      longint  s [3];
      longint  t [3];
      longint  acc;
      longint  rv;
      matrix_t e;
      quat_to_mat(lane(par_rot, 0), lane(par_rot, 1), lane(par_rot, 2), lane(par_rot, 3), pm);
      quat_to_mat(longint'(p.rot[0]), longint'(p.rot[1]), longint'(p.rot[2]),
                  longint'(p.rot[3]), lm);
      for (int c = 0; c < 3; c++) begin
        s[c] = lane(64'(par_scale), c) * longint'(p.scl[c]);
        t[c] = (lane(64'(par_pos), c) + longint'(p.pos[c])) * 256;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += pm[r][k] * lm[k][c];
          rv = round_shift(acc, 16);
          e.m[r*4 + c] = clamp32(round_shift(rv * s[c], 16));
        end
        e.m[r*4 + 3] = trs_mc_pkg::fix32_t'(t[r]);
      end
      return e;
    endfunction

    function void note_pose(pose_t p);
      expected_matrices = {expected_matrices, compose_matrix(p)};
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_matrix(matrix_t got);
      matrix_t e;
      if (expected_matrices.size() == 0) begin
        report_mismatch("result with no transfer waiting");
        return;
      end
      e = expected_matrices.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (got.m[i] !== e.m[i])
          report_mismatch($sformatf("m%0d%0d got %h exp %h", i / 4, i % 4, got.m[i], e.m[i]));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  trs_mc_pkg::fix16_t    in_pos_x, in_pos_y, in_pos_z;
  trs_mc_pkg::fix16_t    in_rot_w, in_rot_x, in_rot_y, in_rot_z;
  trs_mc_pkg::fix16_t    in_scale_x, in_scale_y, in_scale_z;
  logic                  cfg_we;
  trs_mc_pkg::cfg_addr_t cfg_addr;
  logic [63:0]           cfg_wdata;
  logic                  out_strobe;
  trs_mc_pkg::fix32_t    out_m00, out_m01, out_m02, out_m03;
  trs_mc_pkg::fix32_t    out_m10, out_m11, out_m12, out_m13;
  trs_mc_pkg::fix32_t    out_m20, out_m21, out_m22, out_m23;

  matrix_scoreboard sb = new();
  int quiet_cycles = 0;

  trs_matrix_compose_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .in_rot_w   (in_rot_w),
    .in_rot_x   (in_rot_x),
    .in_rot_y   (in_rot_y),
    .in_rot_z   (in_rot_z),
    .in_scale_x (in_scale_x),
    .in_scale_y (in_scale_y),
    .in_scale_z (in_scale_z),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_m00    (out_m00),
    .out_m01    (out_m01),
    .out_m02    (out_m02),
    .out_m03    (out_m03),
    .out_m10    (out_m10),
    .out_m11    (out_m11),
    .out_m12    (out_m12),
    .out_m13    (out_m13),
    .out_m20    (out_m20),
    .out_m21    (out_m21),
    .out_m22    (out_m22),
    .out_m23    (out_m23)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic pose_t mk_pose(int px, int py, int pz, int rw, int rx, int ry, int rz,
                                    int sx, int sy, int sz);
    pose_t p;
    p.pos[0] = trs_mc_pkg::fix16_t'(px);
    p.pos[1] = trs_mc_pkg::fix16_t'(py);
    p.pos[2] = trs_mc_pkg::fix16_t'(pz);
    p.rot[0] = trs_mc_pkg::fix16_t'(rw);
    p.rot[1] = trs_mc_pkg::fix16_t'(rx);
    p.rot[2] = trs_mc_pkg::fix16_t'(ry);
    p.rot[3] = trs_mc_pkg::fix16_t'(rz);
    p.scl[0] = trs_mc_pkg::fix16_t'(sx);
    p.scl[1] = trs_mc_pkg::fix16_t'(sy);
    p.scl[2] = trs_mc_pkg::fix16_t'(sz);
    return p;
  endfunction

  function automatic trs_mc_pkg::fix16_t edge16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4: return 16'sh0001;
      default: return trs_mc_pkg::fix16_t'($urandom);
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    int    mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = (mode == 2) ? edge16() : trs_mc_pkg::fix16_t'($urandom);
      case (mode)
        1:       p.scl[i] = trs_mc_pkg::fix16_t'($urandom_range(0, 1024) - 512);
        2:       p.scl[i] = edge16();
        default: p.scl[i] = trs_mc_pkg::fix16_t'($urandom);
      endcase
    end
    for (int i = 0; i < 4; i++) begin
      case (mode)
        1:       p.rot[i] = trs_mc_pkg::fix16_t'($urandom_range(0, 32768) - 16384);
        2:       p.rot[i] = edge16();
        default: p.rot[i] = trs_mc_pkg::fix16_t'($urandom);
      endcase
    end
    return p;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] parent_word(int kind, bit is_rot);
    logic [63:0] w;
    case (kind)
      2: w = {4{16'h7FFF}};
      3: w = {4{16'h8000}};
      4: w = {4{16'hFFFF}};
      5: begin
        for (int i = 0; i < 4; i++)
          w[16*i +: 16] = is_rot ? 16'($urandom_range(0, 32768) - 16384)
                                 : 16'($urandom_range(0, 1024) - 512);
      end
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task drive_fields(pose_t p);
    in_pos_x   <= p.pos[0];
    in_pos_y   <= p.pos[1];
    in_pos_z   <= p.pos[2];
    in_rot_w   <= p.rot[0];
    in_rot_x   <= p.rot[1];
    in_rot_y   <= p.rot[2];
    in_rot_z   <= p.rot[3];
    in_scale_x <= p.scl[0];
    in_scale_y <= p.scl[1];
    in_scale_z <= p.scl[2];
  endtask

  task send_pose(pose_t p, int gap);
    start <= 1'b1;
    drive_fields(p);
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      drive_fields(rand_pose());
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task program_parent(logic [63:0] pos_w, logic [63:0] rot_w, logic [63:0] scale_w,
                      bit spare);
    cfg_we    <= 1'b1;
    cfg_addr  <= trs_mc_pkg::CFG_PARENT_POS;
    cfg_wdata <= pos_w;
    @(posedge clk);
    cfg_addr  <= trs_mc_pkg::CFG_PARENT_ROT;
    cfg_wdata <= rot_w;
    @(posedge clk);
    cfg_addr  <= trs_mc_pkg::CFG_PARENT_SCALE;
    cfg_wdata <= scale_w;
    @(posedge clk);
    if (spare) begin
      cfg_addr  <= CFG_ADDR_SPARE;
      cfg_wdata <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    matrix_t got;
    pose_t   p;
    if (rst_n && cfg_we) sb.write_reg(cfg_addr, cfg_wdata);
    if (rst_n && start && !busy) begin
      p.pos = '{in_pos_x, in_pos_y, in_pos_z};
      p.rot = '{in_rot_w, in_rot_x, in_rot_y, in_rot_z};
      p.scl = '{in_scale_x, in_scale_y, in_scale_z};
      sb.note_pose(p);
    end
    if (rst_n && out_strobe) begin
      got.m = '{out_m00, out_m01, out_m02, out_m03, out_m10, out_m11, out_m12, out_m13,
                out_m20, out_m21, out_m22, out_m23};
      sb.check_matrix(got);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pose_t directed [$];
    int    kind;
    bit    no_gaps;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= trs_mc_pkg::CFG_PARENT_POS;
    cfg_wdata <= '0;
    drive_fields(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    directed = {directed, mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, mk_pose(0, 0, 0, 16384, 0, 0, 0, 256, 256, 256)};
    directed = {directed, mk_pose(32767, 32767, 32767, 16384, 0, 0, 0, 256, 256, 256)};
    directed = {directed, mk_pose(-32768, -32768, -32768, 16384, 0, 0, 0, 256, 256, 256)};
    directed = {directed, mk_pose(100, -100, 7, -32768, 0, 0, 0, 256, 256, 256)};
    directed = {directed, mk_pose(1, 2, 3, 32767, 32767, 32767, 32767, 256, 256, 256)};
    directed = {directed, mk_pose(0, 0, 0, -32768, -32768, -32768, -32768,
                                  256, 256, 256)};
    directed = {directed, mk_pose(0, 0, 0, 0, 16384, 0, 0, 256, 256, 256)};
    directed = {directed, mk_pose(0, 0, 0, 11585, 0, 11585, 0, 512, 128, 256)};
    directed = {directed, mk_pose(0, 0, 0, 11585, 0, 0, 11585, 256, 512, 768)};
    directed = {directed, mk_pose(0, 0, 0, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767)};
    directed = {directed, mk_pose(0, 0, 0, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768)};
    directed = {directed, mk_pose(5, 5, 5, 16384, 0, 0, 0, 0, 0, 0)};
    directed = {directed, mk_pose(5, 5, 5, 16384, 0, 0, 0, -256, -1, -32768)};
    directed = {directed, mk_pose(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                                  16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA)};
    directed = {directed, mk_pose(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                                  16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555)};
    foreach (directed[i]) send_pose(directed[i], rand_gap());

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: kind = 2;
        1: kind = 3;
        2: kind = 4;
        3: kind = 1;
        4: kind = 0;
        default: kind = $urandom_range(0, 5);
      endcase
      if (kind == 0)
        program_parent(64'(trs_mc_pkg::PARENT_POS_RST), trs_mc_pkg::PARENT_ROT_RST,
                       64'(trs_mc_pkg::PARENT_SCALE_RST), 1'($urandom_range(0, 1)));
      else
        program_parent(parent_word(kind, 1'b0), parent_word(kind, 1'b1),
                       parent_word(kind, 1'b0), 1'($urandom_range(0, 1)));
      no_gaps = (ph % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 149) == 0) drain();
        send_pose(rand_pose(), no_gaps ? 0 : rand_gap());
      end
    end

    drain();
    repeat (trs_mc_pkg::PIPE_LATENCY + 4) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### trs_matrix_compose_top.f
+incdir+rtl
rtl/trs_mc_pkg.sv
rtl/trs_mc_qmat.sv
rtl/trs_mc_matmul.sv
rtl/trs_mc_scale.sv
rtl/trs_matrix_compose_top.sv
tb/tb_trs_matrix_compose_top.sv
